// ===== sv/rrh_pkg.sv =====
// ============================================================================
// rrh_pkg: shared types and constants of the radial ring histogram
// Field widths, store geometry and the handshake structs between the
// ring calculator, the bin store and the top level.
// ============================================================================
package rrh_pkg;

    // Geometry
    localparam int COORD_BITS = 16;
    localparam int MAX_RINGS  = 1024;
    localparam int BIN_AW     = $clog2(MAX_RINGS);

    // Field widths
    localparam int REQ_W     = 2;
    localparam int RING_W    = 11;
    localparam int COUNT_W   = 32;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 2;

    // Datapath widths
    localparam int MAG_W = COORD_BITS;
    localparam int D2_W  = 2 * MAG_W;
    localparam int HH_W  = 2 * CFG_W;
    localparam int MUL_W = (MAG_W > CFG_W) ? MAG_W : CFG_W;
    localparam int CMP_W = (D2_W > HH_W) ? D2_W : HH_W;
    localparam int SUM_W = MUL_W + 1;
    localparam int DIV_W = CFG_W + 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_SIDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_STEP = 2'd1;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] HALF_SIDE_RST = 15'd64;
    localparam logic [CFG_W-1:0] RING_STEP_RST = 15'd1;

    typedef enum logic [REQ_W-1:0] {
        REQ_ACCUM = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        BIN_INC,
        BIN_READ,
        BIN_CLEAR
    } bin_op_t;

    typedef struct packed {
        logic              valid;
        bin_op_t           op;
        logic [BIN_AW-1:0] addr;
    } bin_cmd_t;

    typedef struct packed {
        logic               valid;
        logic               busy;
        logic [COUNT_W-1:0] count;
    } bin_rsp_t;

    typedef struct packed {
        logic              done;
        logic [RING_W-1:0] ring;
    } ring_rsp_t;

    typedef enum logic [1:0] {
        B_SWEEP,
        B_IDLE,
        B_ACCESS
    } bin_state_t;

    typedef enum logic [3:0] {
        RS_IDLE,
        RS_SQX,
        RS_SQY,
        RS_SQH,
        RS_SUM,
        RS_CMP,
        RS_SQRT,
        RS_DIV,
        RS_DONE
    } ring_state_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_RING,
        T_BIN,
        T_CLEAR,
        T_OUT
    } top_state_t;

endpackage

// ===== sv/rrh_sqrt.sv =====
// ============================================================================
// rrh_sqrt: iterative ceiling square root
// Two radicand bits per cycle; done pulses in the cycle after the last step.
// ============================================================================
module rrh_sqrt
    import rrh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [D2_W-1:0]  radicand,
    output logic             done,
    output logic [MAG_W-1:0] root
);

    localparam int CNT_W = $clog2(MAG_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(MAG_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [D2_W-1:0]  n_reg;
    logic [MAG_W:0]   rem_reg;
    logic [MAG_W-1:0] root_reg;

    logic [MAG_W+2:0] rem_sh;
    logic [MAG_W+2:0] trial;
    logic [MAG_W+2:0] diff;
    logic             fits;

    assign rem_sh = {rem_reg, n_reg[D2_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign diff   = rem_sh - trial;
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == LAST)
                    busy_reg <= 1'b0;
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            n_reg    <= {n_reg[D2_W-3:0], 2'b00};
            rem_reg  <= fits ? diff[MAG_W:0] : rem_sh[MAG_W:0];
            root_reg <= {root_reg[MAG_W-2:0], fits};
        end
    end

    // round up when a remainder is left
    assign done = done_reg;
    assign root = root_reg + MAG_W'(rem_reg != '0);

endmodule

// ===== sv/rrh_div.sv =====
// ============================================================================
// rrh_div: iterative restoring divider
// One quotient bit per cycle; done pulses in the cycle after the last bit.
// ============================================================================
module rrh_div
    import rrh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [CFG_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CFG_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [CFG_W-1:0] dvs_reg;

    logic [CFG_W:0] rem_sh;
    logic [CFG_W:0] diff;
    logic           fits;

    assign rem_sh = {rem_reg, quo_reg[DIV_W-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};
    assign fits   = (rem_sh >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == LAST)
                    busy_reg <= 1'b0;
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[CFG_W-1:0] : rem_sh[CFG_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/rrh_ring.sv =====
// ============================================================================
// rrh_ring: ring index calculator
// Squares both magnitudes and the half side on one shared multiplier; inside
// the half side, takes the ceiling root and its ceiling quotient by ring step.
// ============================================================================
module rrh_ring
    import rrh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MAG_W-1:0]  x_pos,
    input  logic [MAG_W-1:0]  y_pos,
    input  logic [CFG_W-1:0]  half_side,
    input  logic [CFG_W-1:0]  ring_step,
    output ring_rsp_t         rsp
);

    ring_state_t state_reg;
    ring_state_t state_next;

    logic [MAG_W-1:0]  mx_reg;
    logic [MAG_W-1:0]  my_reg;
    logic [CFG_W-1:0]  hs_reg;
    logic [CFG_W-1:0]  step_reg;
    logic [D2_W-1:0]   xx_reg;
    logic [D2_W-1:0]   yy_reg;
    logic [HH_W-1:0]   hh_reg;
    logic [D2_W-1:0]   d2_reg;
    logic              outer_reg;
    logic              outer_next;
    logic [RING_W-1:0] ring_reg;
    logic [RING_W-1:0] ring_next;

    logic [MUL_W-1:0]   mul_op;
    logic [2*MUL_W-1:0] mul_p;
    logic [MAG_W-1:0]   mag_x;
    logic [MAG_W-1:0]   mag_y;
    logic               sqrt_start;
    logic               sqrt_done;
    logic [MAG_W-1:0]   sqrt_root;
    logic               div_start;
    logic               div_done;
    logic [DIV_W-1:0]   div_dividend;
    logic [DIV_W-1:0]   div_quo;
    logic [SUM_W-1:0]   inner_sum;
    logic [DIV_W:0]     ring_full;

    // two's complement magnitude; the most negative code maps to 2^(n-1)
    assign mag_x = x_pos[MAG_W-1] ? (~x_pos + 1'b1) : x_pos;
    assign mag_y = y_pos[MAG_W-1] ? (~y_pos + 1'b1) : y_pos;

    assign mul_p     = mul_op * mul_op;
    assign inner_sum = SUM_W'(sqrt_root) + SUM_W'(step_reg) - SUM_W'(1);
    assign ring_full = (DIV_W+1)'(div_quo) + (DIV_W+1)'(outer_reg);

    rrh_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (d2_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    rrh_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (step_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= RS_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        mul_op       = '0;
        sqrt_start   = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        outer_next   = outer_reg;
        ring_next    = ring_reg;
        case (state_reg)
            RS_IDLE:
            begin
                if (start)
                    state_next = RS_SQX;
            end
            RS_SQX:
            begin
                mul_op     = MUL_W'(mx_reg);
                state_next = RS_SQY;
            end
            RS_SQY:
            begin
                mul_op     = MUL_W'(my_reg);
                state_next = RS_SQH;
            end
            RS_SQH:
            begin
                mul_op     = MUL_W'(hs_reg);
                state_next = RS_SUM;
            end
            RS_SUM:
            begin
                state_next = RS_CMP;
            end
            RS_CMP:
            begin
                if (d2_reg == '0)
                begin
                    ring_next  = RING_W'(1);
                    state_next = RS_DONE;
                end
                else if (CMP_W'(d2_reg) > CMP_W'(hh_reg))
                begin
                    // beyond the half side: outer ring
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(hs_reg);
                    outer_next   = 1'b1;
                    state_next   = RS_DIV;
                end
                else
                begin
                    sqrt_start = 1'b1;
                    state_next = RS_SQRT;
                end
            end
            RS_SQRT:
            begin
                if (sqrt_done)
                begin
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(inner_sum);
                    outer_next   = 1'b0;
                    state_next   = RS_DIV;
                end
            end
            RS_DIV:
            begin
                if (div_done)
                begin
                    if (ring_full > (DIV_W+1)'(MAX_RINGS))
                        ring_next = RING_W'(MAX_RINGS);
                    else
                        ring_next = RING_W'(ring_full);
                    state_next = RS_DONE;
                end
            end
            RS_DONE:
            begin
                state_next = RS_IDLE;
            end
            default:
            begin
                state_next = RS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == RS_IDLE) && start)
        begin
            mx_reg   <= mag_x;
            my_reg   <= mag_y;
            hs_reg   <= half_side;
            step_reg <= (ring_step == '0) ? CFG_W'(1) : ring_step;
        end
        if (state_reg == RS_SQX)
            xx_reg <= D2_W'(mul_p);
        if (state_reg == RS_SQY)
            yy_reg <= D2_W'(mul_p);
        if (state_reg == RS_SQH)
            hh_reg <= HH_W'(mul_p);
        if (state_reg == RS_SUM)
            d2_reg <= xx_reg + yy_reg;
        outer_reg <= outer_next;
        ring_reg  <= ring_next;
    end

    assign rsp.done = (state_reg == RS_DONE);
    assign rsp.ring = ring_reg;

endmodule

// ===== sv/rrh_bins.sv =====
// ============================================================================
// rrh_bins: ring count store
// Synchronous memory with separate read and write ports; read-modify-write
// increment, read, and a clearing sweep after reset and on a clear command.
// ============================================================================
module rrh_bins
    import rrh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  bin_cmd_t cmd,
    output bin_rsp_t rsp
);

    localparam logic [BIN_AW-1:0] LAST_ADDR = BIN_AW'(MAX_RINGS - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    logic [COUNT_W-1:0] bin_mem [MAX_RINGS];

    bin_state_t         state_reg;
    bin_state_t         state_next;
    logic [BIN_AW-1:0]  sweep_reg;
    logic [BIN_AW-1:0]  sweep_next;
    logic               report_reg;
    logic               report_next;
    logic [BIN_AW-1:0]  addr_reg;
    bin_op_t            op_reg;
    logic [COUNT_W-1:0] rd_data_reg;

    logic               mem_we;
    logic [BIN_AW-1:0]  mem_waddr;
    logic [COUNT_W-1:0] mem_wdata;
    logic [COUNT_W-1:0] count_inc;

    // saturate at all ones
    assign count_inc = (rd_data_reg == COUNT_MAX) ? rd_data_reg : rd_data_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_SWEEP;
            sweep_reg  <= '0;
            report_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sweep_reg  <= sweep_next;
            report_reg <= report_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        sweep_next  = sweep_reg;
        report_next = report_reg;
        mem_we      = 1'b0;
        mem_waddr   = addr_reg;
        mem_wdata   = count_inc;
        rsp.valid   = 1'b0;
        rsp.busy    = 1'b0;
        rsp.count   = rd_data_reg;
        case (state_reg)
            B_SWEEP:
            begin
                rsp.busy   = 1'b1;
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg;
                mem_wdata  = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_ADDR)
                begin
                    rsp.valid   = report_reg;
                    rsp.count   = '0;
                    report_next = 1'b0;
                    state_next  = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.op == BIN_CLEAR)
                    begin
                        sweep_next  = '0;
                        report_next = 1'b1;
                        state_next  = B_SWEEP;
                    end
                    else
                    begin
                        state_next = B_ACCESS;
                    end
                end
            end
            B_ACCESS:
            begin
                // read data is back; one item at a time, so no overlap to forward
                rsp.valid = 1'b1;
                if (op_reg == BIN_INC)
                begin
                    mem_we    = 1'b1;
                    rsp.count = count_inc;
                end
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == B_IDLE) && cmd.valid)
        begin
            addr_reg <= cmd.addr;
            op_reg   <= cmd.op;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            bin_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= bin_mem[cmd.addr];
    end

endmodule

// ===== sv/radial_ring_histogram_unit.sv =====
// ============================================================================
// radial_ring_histogram_unit: radial ring histogram of lattice positions
// Accumulates positions into concentric ring bins, clears and reads bins.
// ============================================================================
// Path to out_valid: an accumulate inside the half side runs the root, then
//   the divide; outside it only the divide, at the origin neither; a read
//   uses the store unless out of range. One transaction is taken at a time.
// Reset and clear: a sweep zeroes the store; in_ready stays low until it ends.
// Configuration writes are taken at any time (cfg_ready is always high).
// A loaded result waits for out_ready while the next request is accepted.
module radial_ring_histogram_unit
    import rrh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [REQ_W-1:0]      req_type,
    input  logic signed [COORD_BITS-1:0] x_pos,
    input  logic signed [COORD_BITS-1:0] y_pos,
    input  logic [RING_W-1:0]     ring_select,
    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [RING_W-1:0]     ring_index,
    output logic [COUNT_W-1:0]    bin_count,
    // configuration channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    top_state_t state_reg;
    top_state_t state_next;

    logic [CFG_W-1:0]   half_side_reg;
    logic [CFG_W-1:0]   ring_step_reg;

    // pending result, held until the output register frees up
    logic [RING_W-1:0]  res_ring_reg;
    logic [RING_W-1:0]  res_ring_next;
    logic [COUNT_W-1:0] res_count_reg;
    logic [COUNT_W-1:0] res_count_next;

    logic               out_valid_reg;
    logic [RING_W-1:0]  ring_index_reg;
    logic [COUNT_W-1:0] bin_count_reg;
    logic               out_load;

    logic               ring_start;
    ring_rsp_t          ring_rsp;
    bin_cmd_t           bin_cmd;
    bin_rsp_t           bin_rsp;

    logic [RING_W-1:0]  ring_m1;
    logic [RING_W-1:0]  sel_m1;
    logic               sel_ok;

    assign ring_m1 = ring_rsp.ring - RING_W'(1);
    assign sel_m1  = ring_select - RING_W'(1);
    assign sel_ok  = (ring_select != '0) && (ring_select <= RING_W'(MAX_RINGS));

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_side_reg <= HALF_SIDE_RST;
            ring_step_reg <= RING_STEP_RST;
        end
        else if (cfg_valid)
        begin
            // indexes beyond the list are dropped
            if (cfg_index == CFG_HALF_SIDE)
                half_side_reg <= cfg_data;
            else if (cfg_index == CFG_RING_STEP)
                ring_step_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Ring calculator and bin store
    // ------------------------------------------------------------------
    rrh_ring u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ring_start),
        .x_pos     (x_pos),
        .y_pos     (y_pos),
        .half_side (half_side_reg),
        .ring_step (ring_step_reg),
        .rsp       (ring_rsp)
    );

    rrh_bins u_bins (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (bin_cmd),
        .rsp   (bin_rsp)
    );

    // ------------------------------------------------------------------
    // Sequencer: accept, dispatch, wait for the unit, hand to the output
    // ------------------------------------------------------------------
    assign in_ready = (state_reg == T_IDLE) && !bin_rsp.busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= T_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        ring_start     = 1'b0;
        bin_cmd.valid  = 1'b0;
        bin_cmd.op     = BIN_READ;
        bin_cmd.addr   = ring_m1[BIN_AW-1:0];
        res_ring_next  = res_ring_reg;
        res_count_next = res_count_reg;
        out_load       = 1'b0;
        case (state_reg)
            T_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    case (req_t'(req_type))
                        REQ_ACCUM:
                        begin
                            ring_start = 1'b1;
                            state_next = T_RING;
                        end
                        REQ_CLEAR:
                        begin
                            bin_cmd.valid  = 1'b1;
                            bin_cmd.op     = BIN_CLEAR;
                            res_ring_next  = '0;
                            res_count_next = '0;
                            state_next     = T_CLEAR;
                        end
                        REQ_READ:
                        begin
                            res_ring_next = ring_select;
                            if (sel_ok)
                            begin
                                bin_cmd.valid = 1'b1;
                                bin_cmd.op    = BIN_READ;
                                bin_cmd.addr  = sel_m1[BIN_AW-1:0];
                                state_next    = T_BIN;
                            end
                            else
                            begin
                                // ring outside the store reads as zero
                                res_count_next = '0;
                                state_next     = T_OUT;
                            end
                        end
                        default:
                        begin
                            // unused request code: drop it, no result
                            state_next = T_IDLE;
                        end
                    endcase
                end
            end
            T_RING:
            begin
                if (ring_rsp.done)
                begin
                    bin_cmd.valid = 1'b1;
                    bin_cmd.op    = BIN_INC;
                    bin_cmd.addr  = ring_m1[BIN_AW-1:0];
                    res_ring_next = ring_rsp.ring;
                    state_next    = T_BIN;
                end
            end
            T_BIN:
            begin
                if (bin_rsp.valid)
                begin
                    res_count_next = bin_rsp.count;
                    state_next     = T_OUT;
                end
            end
            T_CLEAR:
            begin
                if (bin_rsp.valid)
                    state_next = T_OUT;
            end
            T_OUT:
            begin
                // hold until the output register is empty or being drained
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        res_ring_reg  <= res_ring_next;
        res_count_reg <= res_count_next;
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            ring_index_reg <= res_ring_reg;
            bin_count_reg  <= res_count_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign ring_index = ring_index_reg;
    assign bin_count  = bin_count_reg;

`ifndef SYNTH
    // ring zero only comes from a clear or an out-of-range read: count is zero
    a_ring_zero_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (ring_index_reg == '0)) |-> (bin_count_reg == '0))
        else $error("ring zero with nonzero count");

    // no transaction is taken while the store sweep runs
    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        bin_rsp.busy |-> !in_ready)
        else $error("request accepted during store sweep");

    // ring result arrives only while the sequencer waits for it
    a_ring_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        ring_rsp.done |-> (state_reg == T_RING))
        else $error("unexpected ring result");

    // store response arrives only while the sequencer waits for it
    a_bin_rsp_expected: assert property (@(posedge clk) disable iff (!rst_n)
        bin_rsp.valid |-> ((state_reg == T_BIN) || (state_reg == T_CLEAR)))
        else $error("unexpected store response");

    // a loaded result is visible on the port in the next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("loaded result not presented");
`endif

endmodule
